// ===== hdl/slcs_pkg.sv =====
`timescale 1ns / 1ps
package slcs_pkg;

  localparam int NUM_CLASSES  = 16;
  localparam int NUM_FEATURES = 1024;

  localparam int CLS_W   = $clog2(NUM_CLASSES);
  localparam int FID_W   = $clog2(NUM_FEATURES);
  localparam int WADDR_W = CLS_W + FID_W;
  localparam int W_DEPTH = NUM_CLASSES << FID_W;

  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 40;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_FEATURE = 2'd1,
    ACT_FINISH  = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_SCAN
  } state_e;

  typedef struct packed {
    action_e                   action;
    logic [5:0]                class_index;
    logic [9:0]                feature_id;
    logic signed [VAL_W-1:0]   operand_value;
  } slcs_in_t;

  typedef struct packed {
    logic [5:0]                score_class;
    logic signed [ACC_W-1:0]   score;
    logic                      is_last;
    logic [5:0]                best_class;
  } slcs_out_t;

endpackage

// ===== hdl/sparse_linear_class_scorer.sv =====
`timescale 1ns / 1ps
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+------------------------------------
// command   | start, busy, item_i            | word taken when start && !busy
// result    | result_valid_o, result_o       | valid per score word, cannot be stalled
//
// Weight write, unused action, out-of-range feature: busy stays low.
// Feature: one shared 16x16 multiplier walks the classes,
//   one class per cycle through the weight RAM read, multiply and accumulate stages.
// Finish: one score word per cycle, arg-max on the last.
// After reset the weight RAM is zeroed one entry a cycle, busy until all
//   NUM_CLASSES << clog2(NUM_FEATURES) entries (16384 by default) are cleared.
module sparse_linear_class_scorer
  import slcs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  slcs_in_t  item_i,
  output logic      result_valid_o,
  output slcs_out_t result_o
);

  state_e state_q, state_d;

  logic [WADDR_W-1:0] clr_q;
  logic [CLS_W-1:0]   cnt_q;
  logic [FID_W-1:0]   fid_q;
  logic signed [VAL_W-1:0] val_q;

  // pipeline: p1 = RAM data returned, p2 = product registered
  logic             p1_vld_q, p1_scan_q;
  logic [CLS_W-1:0] p1_cls_q;
  logic             p2_vld_q;
  logic [CLS_W-1:0] p2_cls_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_s_q;

  logic signed [ACC_W-1:0] best_val_q, best_val_d;
  logic [CLS_W-1:0]        best_idx_q, best_idx_d;

  logic      out_vld_q;
  slcs_out_t out_q, out_d;

  logic accept, cls_ok, fid_ok, cnt_last, clr_last;
  logic issue_mac, issue_scan, clearing;

  logic               w_we;
  logic [WADDR_W-1:0] w_waddr, w_raddr;
  logic [VAL_W-1:0]   w_wdata, w_rdata;

  logic             a_we;
  logic [CLS_W-1:0] a_waddr, a_raddr;
  logic [ACC_W-1:0] a_wdata, a_rdata;

  logic signed [ACC_W:0]   sum_w;
  logic signed [ACC_W-1:0] sat_w;
  logic                    better;

  assign busy     = (state_q != ST_IDLE) || p1_vld_q || p2_vld_q;
  assign accept   = start && !busy;
  assign cls_ok   = {1'b0, item_i.class_index} < 7'(NUM_CLASSES);
  assign fid_ok   = {1'b0, item_i.feature_id} < 11'(NUM_FEATURES);
  assign cnt_last = cnt_q == CLS_W'(NUM_CLASSES - 1);
  assign clr_last = clr_q == WADDR_W'(W_DEPTH - 1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && item_i.action == ACT_FEATURE && fid_ok) begin
          state_d = ST_MAC;
        end else if (accept && item_i.action == ACT_FINISH) begin
          state_d = ST_SCAN;
        end
      end
      ST_MAC, ST_SCAN: begin
        if (cnt_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    issue_mac  = 1'b0;
    issue_scan = 1'b0;
    clearing   = 1'b0;
    unique case (state_q)
      ST_CLEAR: clearing   = 1'b1;
      ST_MAC:   issue_mac  = 1'b1;
      ST_SCAN:  issue_scan = 1'b1;
      default: ;
    endcase
  end

  // weight store
  assign w_we    = clearing || (accept && item_i.action == ACT_WRITE && cls_ok && fid_ok);
  assign w_waddr = clearing ? clr_q
                            : {item_i.class_index[CLS_W-1:0], item_i.feature_id[FID_W-1:0]};
  assign w_wdata = clearing ? '0 : item_i.operand_value;
  assign w_raddr = {cnt_q, fid_q};

  slcs_ram #(.WIDTH(VAL_W), .DEPTH(W_DEPTH)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  // saturating accumulate
  assign sum_w = {acc_s_q[ACC_W-1], acc_s_q} + (ACC_W+1)'(prod_q);
  always_comb begin
    sat_w = sum_w[ACC_W-1:0];
    if (sum_w[ACC_W] != sum_w[ACC_W-1]) begin
      sat_w = sum_w[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  // accumulator store: clear pass, accumulate write-back, or zero after readout
  always_comb begin
    a_we    = 1'b0;
    a_waddr = p2_cls_q;
    a_wdata = sat_w;
    if (clearing) begin
      a_we    = clr_q < WADDR_W'(NUM_CLASSES);
      a_waddr = clr_q[CLS_W-1:0];
      a_wdata = '0;
    end else if (p2_vld_q) begin
      a_we = 1'b1;
    end else if (p1_vld_q && p1_scan_q) begin
      a_we    = 1'b1;
      a_waddr = p1_cls_q;
      a_wdata = '0;
    end
  end
  assign a_raddr = cnt_q;

  slcs_ram #(.WIDTH(ACC_W), .DEPTH(NUM_CLASSES)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  // arg-max, first maximum wins
  assign better = (p1_cls_q == '0) || ($signed(a_rdata) > best_val_q);
  always_comb begin
    best_val_d = better ? $signed(a_rdata) : best_val_q;
    best_idx_d = better ? p1_cls_q : best_idx_q;
    out_d.score_class = 6'(p1_cls_q);
    out_d.score       = $signed(a_rdata);
    out_d.is_last     = p1_cls_q == CLS_W'(NUM_CLASSES - 1);
    out_d.best_class  = out_d.is_last ? 6'(best_idx_d) : 6'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      cnt_q     <= '0;
      p1_vld_q  <= 1'b0;
      p1_scan_q <= 1'b0;
      p2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      p1_vld_q  <= issue_mac || issue_scan;
      p1_scan_q <= issue_scan;
      p2_vld_q  <= p1_vld_q && !p1_scan_q;
      out_vld_q <= p1_vld_q && p1_scan_q;
      if (clearing) clr_q <= clr_q + 1'b1;
      if (accept) begin
        cnt_q <= '0;
      end else if (issue_mac || issue_scan) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fid_q <= item_i.feature_id[FID_W-1:0];
      val_q <= item_i.operand_value;
    end
    p1_cls_q <= cnt_q;
    p2_cls_q <= p1_cls_q;
    prod_q   <= val_q * $signed(w_rdata);
    acc_s_q  <= $signed(a_rdata);
    if (p1_vld_q && p1_scan_q) begin
      best_val_q <= best_val_d;
      best_idx_q <= best_idx_d;
      out_q      <= out_d;
    end
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

`ifndef SYNTHESIS
  a_no_wb_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(p2_vld_q && p1_vld_q && p1_scan_q))
    else $error("accumulate write-back overlaps score readout");

  a_last_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.is_last |=> !result_valid_o)
    else $error("score word after last of vector");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> busy && !result_valid_o && !p1_vld_q)
    else $error("activity during weight clear pass");

  a_busy_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_vld_q && !p1_scan_q |-> busy)
    else $error("idle while accumulation in flight");
`endif

endmodule

// ===== hdl/slcs_ram.sv =====
`timescale 1ns / 1ps
module slcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
